// ----- hw/rtl/fixed_range_mtrr_emulator_defines.svh -----
// ----------------------------------------------------------------------------
// fixed_range_mtrr_emulator_defines
// Assertion macros used by the fixed-range MTRR emulator top module.
// ----------------------------------------------------------------------------
`ifndef FIXED_RANGE_MTRR_EMULATOR_DEFINES_SVH
`define FIXED_RANGE_MTRR_EMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/frme_pkg.sv -----
// ----------------------------------------------------------------------------
// frme_pkg
// Types, register numbers and helper functions of the fixed-range MTRR block.
// ----------------------------------------------------------------------------
package frme_pkg;

    localparam int unsigned NUM_FIXED = 11;
    localparam int unsigned WIDX_W    = 4;
    localparam logic [WIDX_W-1:0] LAST_WORD = 4'd10;

    localparam logic [31:0] MSR_CAP       = 32'h0000_00FE;
    localparam logic [31:0] MSR_DEFTYPE   = 32'h0000_02FF;
    localparam logic [31:0] MSR_FIX64K    = 32'h0000_0250;
    localparam logic [31:0] MSR_FIX16K_80 = 32'h0000_0258;
    localparam logic [31:0] MSR_FIX16K_A0 = 32'h0000_0259;
    localparam logic [31:0] MSR_FIX4K_LO  = 32'h0000_0268;
    localparam logic [31:0] MSR_FIX4K_HI  = 32'h0000_026F;

    localparam logic [63:0] ALL_WB        = 64'h0606_0606_0606_0606;
    localparam logic [63:0] DEFTYPE_RESET = 64'h0000_0000_0000_0C00;
    localparam logic [63:0] CAP_RESET     = 64'h0000_0000_0000_0100;
    localparam logic [20:0] LOW_MB        = 21'h10_0000;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    localparam logic [2:0] MT_UC = 3'd0;

    localparam int unsigned BIT_E   = 11;
    localparam int unsigned BIT_FE  = 10;
    localparam int unsigned BIT_FIX = 8;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_BUSY    = 2'd2,
        STAT_NO_WALK = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic              vld;
        logic [WIDX_W-1:0] idx;
    } slot_t;

    // one merged run inside a fixed word
    typedef struct packed {
        logic [7:0] raw;
        logic [3:0] len;
        logic       full;
        logic [2:0] next_sub;
    } run_t;

    function automatic slot_t slot_decode(input logic [31:0] msr);
        slot_t s;
        s.vld = 1'b1;
        s.idx = '0;
        if (msr == MSR_FIX64K) begin
            s.idx = 4'd0;
        end else if (msr == MSR_FIX16K_80) begin
            s.idx = 4'd1;
        end else if (msr == MSR_FIX16K_A0) begin
            s.idx = 4'd2;
        end else if (msr >= MSR_FIX4K_LO && msr <= MSR_FIX4K_HI) begin
            s.idx = {1'b0, msr[2:0]} + 4'd3;
        end else begin
            s.vld = 1'b0;
        end
        return s;
    endfunction

    // WC, WT, WP and WB pass, everything else is UC
    function automatic logic [2:0] translate_type(input logic [7:0] raw);
        logic [2:0] t;
        t = MT_UC;
        if (raw inside {8'd1, 8'd4, 8'd5, 8'd6}) begin
            t = raw[2:0];
        end
        return t;
    endfunction

    function automatic logic [19:0] word_start(input logic [WIDX_W-1:0] w);
        logic [19:0] a;
        case (w)
            4'd0:    a = 20'h00000;
            4'd1:    a = 20'h80000;
            4'd2:    a = 20'hA0000;
            4'd3:    a = 20'hC0000;
            4'd4:    a = 20'hC8000;
            4'd5:    a = 20'hD0000;
            4'd6:    a = 20'hD8000;
            4'd7:    a = 20'hE0000;
            4'd8:    a = 20'hE8000;
            4'd9:    a = 20'hF0000;
            default: a = 20'hF8000;
        endcase
        return a;
    endfunction

    // log2 of the subrange size of a word
    function automatic logic [4:0] sub_shift(input logic [WIDX_W-1:0] w);
        logic [4:0] sh;
        case (w)
            4'd0:       sh = 5'd16;
            4'd1, 4'd2: sh = 5'd14;
            default:    sh = 5'd12;
        endcase
        return sh;
    endfunction

endpackage

// ----- hw/rtl/frme_store.sv -----
// ----------------------------------------------------------------------------
// frme_store
// Fixed-range word memory: one write and one registered read per cycle.
// Entries never written read back as all write-back.
// ----------------------------------------------------------------------------
module frme_store
    import frme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [WIDX_W-1:0] rd_addr,
    output logic [63:0]       rd_data,
    input  logic              wr_en,
    input  logic [WIDX_W-1:0] wr_addr,
    input  logic [63:0]       wr_data
);

    logic [63:0]          mem [0:NUM_FIXED-1];
    logic [NUM_FIXED-1:0] written_reg;
    logic [63:0]          rd_data_reg;
    logic                 rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : ALL_WB;

endmodule

// ----- hw/rtl/frme_merge.sv -----
// ----------------------------------------------------------------------------
// frme_merge
// Finds the run of equal type bytes in a fixed word from a given subrange.
// ----------------------------------------------------------------------------
module frme_merge
    import frme_pkg::*;
(
    input  logic [63:0] word,
    input  logic [2:0]  sub,
    output run_t        run
);

    logic [7:0] raw;
    logic [7:0] breaks;
    logic [3:0] stop;

    assign raw = word[{sub, 3'b000} +: 8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            breaks[k] = (4'(k) > {1'b0, sub}) && (word[8*k +: 8] != raw);
        end
    end

    // first differing byte above the start, or 8 when the run reaches the end
    always_comb begin
        stop = 4'd8;
        for (int k = 7; k >= 0; k--) begin
            if (breaks[k]) begin
                stop = 4'(k);
            end
        end
    end

    always_comb begin
        run.raw      = raw;
        run.len      = stop - {1'b0, sub};
        run.full     = stop[3];
        run.next_sub = stop[2:0];
    end

endmodule

// ----- hw/rtl/fixed_range_mtrr_emulator.sv -----
// ----------------------------------------------------------------------------
// fixed_range_mtrr_emulator
// Fixed-range MTRR register block with a memory-type walk of the low megabyte.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one item per request: read, write or walk step.
//   Every accepted item gives exactly one item on the m_ channel.
//   cfg_we/cfg_wdata load the capability word; write it only while idle.
//   Per item, the accept cycle reads the fixed-word memory (one registered
//   read port), the next cycle computes and loads the result register; no
//   new item is taken until that result register has been loaded.
//   A walk step merges equal type bytes of one stored word in its compute cycle.
//   The result register sits apart from the input side: a new item is taken
//   while a result still waits. If the receiver stalls with m_ready low, the
//   following item holds in its compute cycle until the result slot frees.
//   Reset (aresetn low, synchronous) restores the capability word, the
//   default-type word and clears the walk; the fixed words read as
//   write-back until first written, with no clearing pass needed.
// ----------------------------------------------------------------------------
`include "fixed_range_mtrr_emulator_defines.svh"

module fixed_range_mtrr_emulator
    import frme_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_msr_address,
    input  logic [63:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_data,
    output logic [1:0]  m_status,
    output logic        m_region_valid,
    output logic [19:0] m_region_start,
    output logic [20:0] m_region_size,
    output logic [2:0]  m_region_type,
    output logic        m_region_last
);

    fsm_t              state_reg, state_next;
    logic [63:0]       cap_reg;
    logic [63:0]       deftype_reg, deftype_next;
    logic              pending_reg, pending_next;
    logic [WIDX_W-1:0] walk_idx_reg, walk_idx_next;
    logic [2:0]        walk_sub_reg, walk_sub_next;

    logic [1:0]        act_reg;
    logic [31:0]       msr_reg;
    logic [63:0]       wval_reg;
    slot_t             slot_reg;

    logic              m_valid_reg, m_valid_next;
    logic [63:0]       rdata_reg, rdata_next;
    status_t           status_reg, status_next;
    logic              rvalid_reg, rvalid_next;
    logic [19:0]       rstart_reg, rstart_next;
    logic [20:0]       rsize_reg, rsize_next;
    logic [2:0]        rtype_reg, rtype_next;
    logic              rlast_reg, rlast_next;

    logic              accept;
    logic              out_load;
    slot_t             in_slot;
    logic [WIDX_W-1:0] rd_addr;
    logic [63:0]       mem_q;
    logic              mem_we;
    run_t              run;
    logic [4:0]        shift;

    assign accept  = s_valid && s_ready;
    assign in_slot = slot_decode(s_msr_address);
    assign rd_addr = (s_action == ACT_STEP) ? walk_idx_reg : in_slot.idx;

    frme_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_q),
        .wr_en   (mem_we),
        .wr_addr (slot_reg.idx),
        .wr_data (wval_reg)
    );

    frme_merge u_merge (
        .word (mem_q),
        .sub  (walk_sub_reg),
        .run  (run)
    );

    assign shift = sub_shift(walk_idx_reg);

    // captured request and result registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_action;
            msr_reg  <= s_msr_address;
            wval_reg <= s_write_value;
            slot_reg <= in_slot;
        end
        if (out_load) begin
            rdata_reg  <= rdata_next;
            rstart_reg <= rstart_next;
            rsize_reg  <= rsize_next;
            rtype_reg  <= rtype_next;
            rlast_reg  <= rlast_next;
            rvalid_reg <= rvalid_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            cap_reg      <= CAP_RESET;
            deftype_reg  <= DEFTYPE_RESET;
            pending_reg  <= 1'b0;
            walk_idx_reg <= '0;
            walk_sub_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            deftype_reg  <= deftype_next;
            pending_reg  <= pending_next;
            walk_idx_reg <= walk_idx_next;
            walk_sub_reg <= walk_sub_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        deftype_next  = deftype_reg;
        pending_next  = pending_reg;
        walk_idx_next = walk_idx_reg;
        walk_sub_next = walk_sub_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        rdata_next    = '0;
        status_next   = STAT_OK;
        rvalid_next   = 1'b0;
        rstart_next   = '0;
        rsize_next    = '0;
        rtype_next    = MT_UC;
        rlast_next    = 1'b0;
        s_ready       = (state_reg == FSM_IDLE);

        case (act_reg)
            ACT_READ: begin
                if (msr_reg == MSR_CAP) begin
                    rdata_next = cap_reg;
                end else if (msr_reg == MSR_DEFTYPE) begin
                    rdata_next = deftype_reg;
                end else if (slot_reg.vld) begin
                    rdata_next = mem_q;
                end else begin
                    status_next = STAT_UNKNOWN;
                end
            end
            ACT_WRITE: begin
                if (msr_reg == MSR_DEFTYPE || slot_reg.vld) begin
                    if (pending_reg) begin
                        status_next = STAT_BUSY;
                    end
                end else begin
                    status_next = STAT_UNKNOWN;
                end
            end
            ACT_STEP: begin
                if (!pending_reg) begin
                    status_next = STAT_NO_WALK;
                end else if (!deftype_reg[BIT_E] || !deftype_reg[BIT_FE]
                             || !cap_reg[BIT_FIX]) begin
                    rvalid_next = 1'b1;
                    rsize_next  = LOW_MB;
                    rtype_next  = deftype_reg[BIT_E] ? translate_type(deftype_reg[7:0])
                                                     : MT_UC;
                    rlast_next  = 1'b1;
                end else begin
                    rvalid_next = 1'b1;
                    rstart_next = word_start(walk_idx_reg) + (20'(walk_sub_reg) << shift);
                    rsize_next  = 21'(run.len) << shift;
                    rtype_next  = translate_type(run.raw);
                    rlast_next  = run.full && (walk_idx_reg == LAST_WORD);
                end
            end
            default: begin
            end
        endcase

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                    // state updates commit together with the result
                    if (act_reg == ACT_WRITE && !pending_reg) begin
                        if (msr_reg == MSR_DEFTYPE) begin
                            if (deftype_reg != wval_reg) begin
                                deftype_next  = wval_reg;
                                pending_next  = 1'b1;
                                walk_idx_next = '0;
                                walk_sub_next = '0;
                            end
                        end else if (slot_reg.vld) begin
                            mem_we = 1'b1;
                        end
                    end
                    if (act_reg == ACT_STEP && pending_reg) begin
                        if (rlast_next) begin
                            pending_next  = 1'b0;
                            walk_idx_next = '0;
                            walk_sub_next = '0;
                        end else if (run.full) begin
                            walk_idx_next = walk_idx_reg + 4'd1;
                            walk_sub_next = '0;
                        end else begin
                            walk_sub_next = run.next_sub;
                        end
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = rdata_reg;
    assign m_status       = status_reg;
    assign m_region_valid = rvalid_reg;
    assign m_region_start = rstart_reg;
    assign m_region_size  = rsize_reg;
    assign m_region_type  = rtype_reg;
    assign m_region_last  = rlast_reg;

    `ASSERT_ALWAYS(a_run_ok, aclk, aresetn, !(m_valid && m_region_valid) || (m_status == STAT_OK))
    `ASSERT_ALWAYS(a_walk_idx_range, aclk, aresetn, walk_idx_reg <= LAST_WORD)
    `ASSERT_NEXT(a_accept_exec, aclk, aresetn, accept, state_reg == FSM_EXEC)
    `ASSERT_NEXT(a_last_ends_walk, aclk, aresetn, out_load && rlast_next, !pending_reg)

endmodule
